>>> design/gbsf_pkg.sv
package gbsf_pkg;

  // parser phases
  localparam logic [3:0] PH_HEADER   = 4'd0;
  localparam logic [3:0] PH_SCREEN   = 4'd1;
  localparam logic [3:0] PH_GTABLE   = 4'd2;
  localparam logic [3:0] PH_BLOCK    = 4'd3;
  localparam logic [3:0] PH_IMGDESC  = 4'd4;
  localparam logic [3:0] PH_LTABLE   = 4'd5;
  localparam logic [3:0] PH_CODESIZE = 4'd6;
  localparam logic [3:0] PH_SUBSIZE  = 4'd7;
  localparam logic [3:0] PH_SUBDATA  = 4'd8;
  localparam logic [3:0] PH_EXTLABEL = 4'd9;

  // status codes
  localparam logic [1:0] STAT_RUN     = 2'd0;
  localparam logic [1:0] STAT_TRAILER = 2'd1;
  localparam logic [1:0] STAT_BADHDR  = 2'd2;
  localparam logic [1:0] STAT_BADBLK  = 2'd3;

  // stream bytes
  localparam logic [7:0] SIG_G       = 8'h47;
  localparam logic [7:0] SIG_I       = 8'h49;
  localparam logic [7:0] SIG_F       = 8'h46;
  localparam logic [7:0] BLK_IMAGE   = 8'h2c;
  localparam logic [7:0] BLK_EXT     = 8'h21;
  localparam logic [7:0] BLK_TRAILER = 8'h3b;
  localparam logic [7:0] LBL_COMMENT = 8'hfe;

  // config register indexes
  localparam int unsigned CfgIdxW   = 2;
  localparam logic [CfgIdxW-1:0] CFG_STRIP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PASS  = 2'd1;

  typedef struct packed {
    logic strip;
    logic pass;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       keep;
    logic [1:0] status;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } step_t;

  // color table size in bytes: 3 * 2^(n+1) when the table flag is set
  function automatic logic [9:0] table_size(logic [7:0] flags);
    logic [9:0] sz;
    sz = 10'd6 << flags[2:0];
    if (!flags[7]) begin
      sz = 10'd0;
    end
    return sz;
  endfunction

  function automatic logic [7:0] sig_byte(logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = SIG_G;
      2'd1:    c = SIG_I;
      default: c = SIG_F;
    endcase
    return c;
  endfunction

endpackage

>>> design/gbsf_parser.sv
module gbsf_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            in_byte_i,
  input  gbsf_pkg::cfg_t        cfg_i,
  output gbsf_pkg::step_t       step_o
);

  logic [3:0] phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic [9:0] tbl_q, tbl_d;
  logic [7:0] sub_q, sub_d;
  logic       first_q, first_d;
  logic       drop_q, drop_d;
  logic [1:0] status_q, status_d;

  logic       keep;
  logic       pair;
  logic [9:0] tbl_dec;
  logic [7:0] sub_dec;
  logic [7:0] b;

  assign b       = in_byte_i;
  assign tbl_dec = (tbl_q != 10'd0) ? tbl_q - 10'd1 : 10'd0;
  assign sub_dec = sub_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    tbl_d    = tbl_q;
    sub_d    = sub_q;
    first_d  = first_q;
    drop_d   = drop_q;
    status_d = status_q;
    keep     = 1'b0;
    pair     = 1'b0;
    if (status_q == gbsf_pkg::STAT_RUN) begin
      case (phase_q)
        gbsf_pkg::PH_HEADER: begin
          if (cnt_q < 4'd3 && b != gbsf_pkg::sig_byte(cnt_q[1:0])) begin
            status_d = gbsf_pkg::STAT_BADHDR;
          end else begin
            keep = 1'b1;
            if (cnt_q >= 4'd5) begin
              cnt_d   = 4'd0;
              phase_d = gbsf_pkg::PH_SCREEN;
            end else begin
              cnt_d = cnt_q + 4'd1;
            end
          end
        end
        gbsf_pkg::PH_SCREEN: begin
          keep = 1'b1;
          if (cnt_q == 4'd4) begin
            tbl_d = gbsf_pkg::table_size(b);
          end
          if (cnt_q >= 4'd6) begin
            cnt_d   = 4'd0;
            phase_d = (tbl_q != 10'd0) ? gbsf_pkg::PH_GTABLE : gbsf_pkg::PH_BLOCK;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        gbsf_pkg::PH_GTABLE, gbsf_pkg::PH_LTABLE: begin
          keep  = 1'b1;
          tbl_d = tbl_dec;
          if (tbl_dec == 10'd0) begin
            phase_d = (phase_q == gbsf_pkg::PH_GTABLE) ? gbsf_pkg::PH_BLOCK
                                                       : gbsf_pkg::PH_CODESIZE;
          end
        end
        gbsf_pkg::PH_IMGDESC: begin
          keep = 1'b1;
          if (cnt_q >= 4'd9) begin
            tbl_d   = gbsf_pkg::table_size(b);
            cnt_d   = 4'd0;
            phase_d = (gbsf_pkg::table_size(b) != 10'd0) ? gbsf_pkg::PH_LTABLE
                                                         : gbsf_pkg::PH_CODESIZE;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
        gbsf_pkg::PH_CODESIZE: begin
          keep    = 1'b1;
          first_d = 1'b0;
          phase_d = gbsf_pkg::PH_SUBSIZE;
        end
        gbsf_pkg::PH_SUBSIZE: begin
          keep = !drop_q;
          if (b != 8'd0) begin
            sub_d   = b;
            first_d = 1'b0;
            phase_d = gbsf_pkg::PH_SUBDATA;
          end else if (first_q) begin
            // zero-length first sub-block of a non-comment extension
            first_d = 1'b0;
          end else begin
            drop_d  = 1'b0;
            phase_d = gbsf_pkg::PH_BLOCK;
          end
        end
        gbsf_pkg::PH_SUBDATA: begin
          keep  = !drop_q;
          sub_d = sub_dec;
          if (sub_dec == 8'd0) begin
            phase_d = gbsf_pkg::PH_SUBSIZE;
          end
        end
        gbsf_pkg::PH_EXTLABEL: begin
          phase_d = gbsf_pkg::PH_SUBSIZE;
          if (b == gbsf_pkg::LBL_COMMENT && cfg_i.strip) begin
            drop_d  = 1'b1;
            first_d = 1'b0;
          end else begin
            drop_d  = 1'b0;
            first_d = (b != gbsf_pkg::LBL_COMMENT);
            pair    = cfg_i.pass;
          end
        end
        default: begin
          // block introducer
          if (b == gbsf_pkg::BLK_IMAGE) begin
            keep    = 1'b1;
            cnt_d   = 4'd1;
            phase_d = gbsf_pkg::PH_IMGDESC;
          end else if (b == gbsf_pkg::BLK_EXT) begin
            phase_d = gbsf_pkg::PH_EXTLABEL;
          end else if (b == gbsf_pkg::BLK_TRAILER) begin
            keep     = 1'b1;
            status_d = gbsf_pkg::STAT_TRAILER;
          end else begin
            status_d = gbsf_pkg::STAT_BADBLK;
          end
        end
      endcase
    end
  end

  // held introducer goes out ahead of the label
  always_comb begin
    step_o.two           = pair;
    step_o.second.data   = b;
    step_o.second.keep   = 1'b1;
    step_o.second.status = status_d;
    step_o.second.last   = 1'b1;
    if (pair) begin
      step_o.first.data = gbsf_pkg::BLK_EXT;
      step_o.first.keep = 1'b1;
      step_o.first.last = 1'b0;
    end else begin
      step_o.first.data = (keep && cfg_i.pass) ? b : 8'd0;
      step_o.first.keep = keep && cfg_i.pass;
      step_o.first.last = 1'b1;
    end
    step_o.first.status = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= gbsf_pkg::PH_HEADER;
      cnt_q    <= 4'd0;
      tbl_q    <= 10'd0;
      sub_q    <= 8'd0;
      first_q  <= 1'b0;
      drop_q   <= 1'b0;
      status_q <= gbsf_pkg::STAT_RUN;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      tbl_q    <= tbl_d;
      sub_q    <= sub_d;
      first_q  <= first_d;
      drop_q   <= drop_d;
      status_q <= status_d;
    end
  end

endmodule

>>> design/gbsf_result_queue.sv
module gbsf_result_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  gbsf_pkg::step_t     step_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gbsf_pkg::result_t   out_o
);

  localparam int unsigned Depth = 3;

  gbsf_pkg::result_t slot_q [Depth];
  gbsf_pkg::result_t slot_d [Depth];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] base;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && out_ready_i;
  assign room_o      = (cnt_q <= 2'd1);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = slot_q[0];
  assign base        = cnt_q - {1'b0, pop};

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      slot_d[i] = (pop && i < Depth - 1) ? slot_q[i+1] : slot_q[i];
      if (push_i && 2'(i) == base) begin
        slot_d[i] = step_i.first;
      end
      if (push_i && step_i.two && 2'(i) == base + 2'd1) begin
        slot_d[i] = step_i.second;
      end
    end
    cnt_d = base;
    if (push_i) begin
      cnt_d = base + (step_i.two ? 2'd2 : 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/gif_block_stream_filter.sv
// GIF block stream filter.
// Input channel: one file byte per request on in_byte_i (in_valid_i/in_ready_o).
// Output channel: one result per request (out_valid_o/out_ready_i) carrying the
// echoed byte, its byte_valid flag, the sticky parse status and a last flag
// marking the final result of an input byte.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 strips
// comment extensions, 1 enables echo); write only while the block is idle.
// A result enters the result queue when its byte is accepted and is presented
// once earlier results drain; one byte per cycle while the receiver keeps up.
// A kept extension label yields two results (held introducer then label); the
// 3-entry result queue then holds two and in_ready_o drops while one drains.
// When the receiver stalls, results collect in the queue; in_ready_o goes low
// once two are waiting, so nothing is lost.
// Reset empties the queue, returns the parser to the header phase with status
// running, clears strip and sets pass enable.
module gif_block_stream_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          byte_valid_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [gbsf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic                          cfg_data_i
);

  gbsf_pkg::cfg_t    cfg_q;
  gbsf_pkg::step_t   step;
  gbsf_pkg::result_t res;
  logic              accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strip <= 1'b0;
      cfg_q.pass  <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gbsf_pkg::CFG_STRIP) begin
        cfg_q.strip <= cfg_data_i;
      end
      if (cfg_idx_i == gbsf_pkg::CFG_PASS) begin
        cfg_q.pass <= cfg_data_i;
      end
    end
  end

  gbsf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .cfg_i     (cfg_q),
    .step_o    (step)
  );

  gbsf_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .step_i      (step),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign out_byte_o   = res.data;
  assign byte_valid_o = res.keep;
  assign status_o     = res.status;
  assign last_o       = res.last;

  // a non-final result is always the held extension introducer
  a_pair_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> byte_valid_o && out_byte_o == gbsf_pkg::BLK_EXT)
    else $error("non-final result is not the extension introducer");

  // the label of a pair is queued together with its introducer
  a_pair_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("second result of a pair missing");

  // status never leaves an error or trailer state
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && status_o != gbsf_pkg::STAT_RUN
    |=> !out_valid_o || status_o == $past(status_o))
    else $error("status changed after it stuck");

  // a byte is accepted only when the queue can take a pair
  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && !last_o |=> !in_ready_o)
    else $error("input accepted while queue full");

endmodule
